@@ rtl/mazeuf_pkg.sv @@
`default_nettype none

package mazeuf_pkg;

    // Request codes and wall sides.
    localparam logic       OP_READ    = 1'b1;
    localparam logic [1:0] SIDE_LEFT  = 2'd0;
    localparam logic [1:0] SIDE_RIGHT = 2'd1;
    localparam logic [1:0] SIDE_UP    = 2'd2;
    localparam logic [1:0] SIDE_DOWN  = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_RD_WAIT,
        ST_F_RD,
        ST_F_CHK,
        ST_C_CHK,
        ST_C_WR,
        ST_WALL_A,
        ST_WALL_B,
        ST_FINISH
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_RD_WALL,
        CMD_FIND_A,
        CMD_FIND_B,
        CMD_P_READ,
        CMD_F_STEP,
        CMD_FOUND,
        CMD_C_WRITE,
        CMD_JOIN,
        CMD_WALL_A,
        CMD_WALL_B,
        CMD_OUT
    } t_dp_cmd;

    typedef enum logic [1:0] {
        RES_REJECT,
        RES_SAME,
        RES_REMOVED,
        RES_READ
    } t_res;

    typedef struct packed {
        t_dp_cmd cmd;
        t_res    res;
    } t_dp_ctrl;

    typedef struct packed {
        logic is_read;
        logic on_board;
        logic reject;
        logic cur_is_root;
        logic cur_eq_root;
        logic roots_equal;
        logic clr_last;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/mazeuf_dp.sv @@
`default_nettype none

module mazeuf_dp #(
    parameter int GRID_SIDE = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mazeuf_pkg::t_dp_ctrl i_ctrl,
    output mazeuf_pkg::t_dp_stat o_stat,
    input  wire                  i_operation,
    input  wire  [3:0]           i_row,
    input  wire  [3:0]           i_column,
    input  wire  [1:0]           i_side,
    output logic                 o_removed,
    output logic                 o_rejected,
    output logic                 o_wall_present
);

    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int IDX_W      = $clog2(CELL_COUNT);
    localparam logic [6:0]       SIDE_V   = 7'(GRID_SIDE);
    localparam logic [IDX_W-1:0] ROW_STEP = IDX_W'(GRID_SIDE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELL_COUNT - 1);

    logic [IDX_W-1:0] r_parent_mem [CELL_COUNT];
    logic [3:0]       r_wall_mem   [CELL_COUNT];

    logic             r_op;
    logic [1:0]       r_side;
    logic             r_on_board;
    logic             r_reject;
    logic [IDX_W-1:0] r_a;
    logic [IDX_W-1:0] r_b;
    logic [IDX_W-1:0] r_cur;
    logic [IDX_W-1:0] r_start;
    logic [IDX_W-1:0] r_root;
    logic [IDX_W-1:0] r_ra;
    logic [IDX_W-1:0] r_pdata;
    logic [3:0]       r_wdata;
    logic [IDX_W-1:0] r_clr;
    logic [IDX_W-1:0] n_clr;

    logic             n_on_board;
    logic             n_reject;
    logic [11:0]      n_lin;
    logic [IDX_W-1:0] n_a;
    logic [IDX_W-1:0] n_b;

    logic             p_we;
    logic             p_re;
    logic [IDX_W-1:0] p_waddr;
    logic [IDX_W-1:0] p_wdata;
    logic             w_we;
    logic             w_re;
    logic [IDX_W-1:0] w_waddr;
    logic [IDX_W-1:0] w_raddr;
    logic [3:0]       w_wdata;
    logic [3:0]       mask_a;
    logic [3:0]       mask_b;

    // Decode of the incoming request.
    always_comb begin
        n_on_board = ({3'b0, i_row} < SIDE_V) && ({3'b0, i_column} < SIDE_V);
        n_reject   = !n_on_board
                     || (i_side == mazeuf_pkg::SIDE_RIGHT)
                     || (i_side == mazeuf_pkg::SIDE_DOWN)
                     || ((i_side == mazeuf_pkg::SIDE_UP) && (i_row == 4'd0))
                     || ((i_side == mazeuf_pkg::SIDE_LEFT) && (i_column == 4'd0));
        n_lin = ({8'b0, i_row} * 12'(GRID_SIDE)) + {8'b0, i_column};
        n_a   = n_lin[IDX_W-1:0];
        n_b   = (i_side == mazeuf_pkg::SIDE_UP) ? (n_a - ROW_STEP) : (n_a - IDX_W'(1));
    end

    always_comb begin
        if (r_side == mazeuf_pkg::SIDE_UP) begin
            mask_a = 4'(1) << mazeuf_pkg::SIDE_UP;
            mask_b = 4'(1) << mazeuf_pkg::SIDE_DOWN;
        end else begin
            mask_a = 4'(1) << mazeuf_pkg::SIDE_LEFT;
            mask_b = 4'(1) << mazeuf_pkg::SIDE_RIGHT;
        end
    end

    // Memory port control.
    always_comb begin
        p_we    = 1'b0;
        p_re    = 1'b0;
        p_waddr = r_cur;
        p_wdata = r_root;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = r_a;
        w_raddr = r_a;
        w_wdata = r_wdata & ~mask_a;
        n_clr   = r_clr;
        unique case (i_ctrl.cmd)
            mazeuf_pkg::CMD_CLEAR: begin
                p_we    = 1'b1;
                p_waddr = r_clr;
                p_wdata = r_clr;
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = 4'hF;
                n_clr   = r_clr + IDX_W'(1);
            end
            mazeuf_pkg::CMD_P_READ: begin
                p_re = 1'b1;
            end
            mazeuf_pkg::CMD_C_WRITE: begin
                p_we = 1'b1;
            end
            mazeuf_pkg::CMD_RD_WALL: begin
                w_re = 1'b1;
            end
            mazeuf_pkg::CMD_JOIN: begin
                p_we    = 1'b1;
                p_waddr = r_ra;
                w_re    = 1'b1;
            end
            mazeuf_pkg::CMD_WALL_A: begin
                w_we    = 1'b1;
                w_re    = 1'b1;
                w_raddr = r_b;
            end
            mazeuf_pkg::CMD_WALL_B: begin
                w_we    = 1'b1;
                w_waddr = r_b;
                w_wdata = r_wdata & ~mask_b;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_parent_mem[p_waddr] <= p_wdata;
        end
        if (p_re) begin
            r_pdata <= r_parent_mem[r_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wall_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_wdata <= r_wall_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else begin
            r_clr <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.cmd)
            mazeuf_pkg::CMD_LOAD: begin
                r_op       <= i_operation;
                r_side     <= i_side;
                r_on_board <= n_on_board;
                r_reject   <= n_reject;
                r_a        <= n_a;
                r_b        <= n_b;
            end
            mazeuf_pkg::CMD_FIND_A: begin
                r_cur   <= r_a;
                r_start <= r_a;
            end
            mazeuf_pkg::CMD_FIND_B: begin
                r_ra    <= r_root;
                r_cur   <= r_b;
                r_start <= r_b;
            end
            mazeuf_pkg::CMD_F_STEP, mazeuf_pkg::CMD_C_WRITE: begin
                r_cur <= r_pdata;
            end
            mazeuf_pkg::CMD_FOUND: begin
                r_root <= r_cur;
                r_cur  <= r_start;
            end
            mazeuf_pkg::CMD_OUT: begin
                o_removed      <= (i_ctrl.res == mazeuf_pkg::RES_REMOVED);
                o_rejected     <= (i_ctrl.res == mazeuf_pkg::RES_REJECT);
                // A read of a cell off the board reports a standing wall.
                o_wall_present <= (i_ctrl.res == mazeuf_pkg::RES_READ)
                                  && (!r_on_board || r_wdata[r_side]);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.is_read     = (r_op == mazeuf_pkg::OP_READ);
        o_stat.on_board    = r_on_board;
        o_stat.reject      = r_reject;
        o_stat.cur_is_root = (r_pdata == r_cur);
        o_stat.cur_eq_root = (r_cur == r_root);
        o_stat.roots_equal = (r_ra == r_root);
        o_stat.clr_last    = (r_clr == LAST_IDX);
    end

endmodule

`default_nettype wire

@@ rtl/mazeuf_ctrl.sv @@
`default_nettype none

module mazeuf_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    input  mazeuf_pkg::t_dp_stat i_stat,
    output mazeuf_pkg::t_dp_ctrl o_ctrl
);

    mazeuf_pkg::t_state r_state;
    mazeuf_pkg::t_state n_state;
    mazeuf_pkg::t_res   r_res;
    mazeuf_pkg::t_res   n_res;
    logic               r_phase;
    logic               n_phase;
    logic               r_out_valid;
    logic               n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mazeuf_pkg::ST_CLEAR;
            r_res       <= mazeuf_pkg::RES_REJECT;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res       <= n_res;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        n_phase    = r_phase;
        o_ctrl.cmd = mazeuf_pkg::CMD_NONE;
        o_ctrl.res = r_res;
        o_in_ready = 1'b0;
        unique case (r_state)
            mazeuf_pkg::ST_CLEAR: begin
                o_ctrl.cmd = mazeuf_pkg::CMD_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = mazeuf_pkg::ST_IDLE;
                end
            end
            mazeuf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.cmd = mazeuf_pkg::CMD_LOAD;
                    n_state    = mazeuf_pkg::ST_CHECK;
                end
            end
            mazeuf_pkg::ST_CHECK: begin
                if (i_stat.is_read) begin
                    n_res = mazeuf_pkg::RES_READ;
                    if (i_stat.on_board) begin
                        o_ctrl.cmd = mazeuf_pkg::CMD_RD_WALL;
                        n_state    = mazeuf_pkg::ST_RD_WAIT;
                    end else begin
                        n_state = mazeuf_pkg::ST_FINISH;
                    end
                end else if (i_stat.reject) begin
                    n_res   = mazeuf_pkg::RES_REJECT;
                    n_state = mazeuf_pkg::ST_FINISH;
                end else begin
                    o_ctrl.cmd = mazeuf_pkg::CMD_FIND_A;
                    n_phase    = 1'b0;
                    n_state    = mazeuf_pkg::ST_F_RD;
                end
            end
            mazeuf_pkg::ST_RD_WAIT: begin
                n_state = mazeuf_pkg::ST_FINISH;
            end
            mazeuf_pkg::ST_F_RD: begin
                o_ctrl.cmd = mazeuf_pkg::CMD_P_READ;
                n_state    = mazeuf_pkg::ST_F_CHK;
            end
            mazeuf_pkg::ST_F_CHK: begin
                if (i_stat.cur_is_root) begin
                    o_ctrl.cmd = mazeuf_pkg::CMD_FOUND;
                    n_state    = mazeuf_pkg::ST_C_CHK;
                end else begin
                    o_ctrl.cmd = mazeuf_pkg::CMD_F_STEP;
                    n_state    = mazeuf_pkg::ST_F_RD;
                end
            end
            mazeuf_pkg::ST_C_CHK: begin
                // Compression walks the path again from the start cell.
                if (!i_stat.cur_eq_root) begin
                    o_ctrl.cmd = mazeuf_pkg::CMD_P_READ;
                    n_state    = mazeuf_pkg::ST_C_WR;
                end else if (!r_phase) begin
                    o_ctrl.cmd = mazeuf_pkg::CMD_FIND_B;
                    n_phase    = 1'b1;
                    n_state    = mazeuf_pkg::ST_F_RD;
                end else if (i_stat.roots_equal) begin
                    n_res   = mazeuf_pkg::RES_SAME;
                    n_state = mazeuf_pkg::ST_FINISH;
                end else begin
                    o_ctrl.cmd = mazeuf_pkg::CMD_JOIN;
                    n_state    = mazeuf_pkg::ST_WALL_A;
                end
            end
            mazeuf_pkg::ST_C_WR: begin
                o_ctrl.cmd = mazeuf_pkg::CMD_C_WRITE;
                n_state    = mazeuf_pkg::ST_C_CHK;
            end
            mazeuf_pkg::ST_WALL_A: begin
                o_ctrl.cmd = mazeuf_pkg::CMD_WALL_A;
                n_state    = mazeuf_pkg::ST_WALL_B;
            end
            mazeuf_pkg::ST_WALL_B: begin
                o_ctrl.cmd = mazeuf_pkg::CMD_WALL_B;
                n_res      = mazeuf_pkg::RES_REMOVED;
                n_state    = mazeuf_pkg::ST_FINISH;
            end
            mazeuf_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctrl.cmd = mazeuf_pkg::CMD_OUT;
                    n_state    = mazeuf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mazeuf_pkg::ST_IDLE;
            end
        endcase
    end

    assign n_out_valid = (o_ctrl.cmd == mazeuf_pkg::CMD_OUT) || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/maze_union_find_wall_carver.sv @@
// A read request reads the wall memory and then registers its result; a rejected offer
// goes straight to the result. An accepted offer finds the root of both cells by walking
// parent pointers, then walks each path again to point it at the root, and joins the sets and
// removes the wall when the roots differ. Requests are handled one at a time; the next one
// is accepted in the cycle after the result is loaded into the output register. After
// reset a clearing pass initializes both memories, with no request accepted meanwhile.
`default_nettype none

module maze_union_find_wall_carver #(
    parameter int GRID_SIDE = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire        i_operation,
    input  wire  [3:0] i_row,
    input  wire  [3:0] i_column,
    input  wire  [1:0] i_side,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic       o_removed,
    output logic       o_rejected,
    output logic       o_wall_present
);

    mazeuf_pkg::t_dp_ctrl dp_ctrl;
    mazeuf_pkg::t_dp_stat dp_stat;

    mazeuf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_ctrl      (dp_ctrl)
    );

    mazeuf_dp #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (dp_ctrl),
        .o_stat         (dp_stat),
        .i_operation    (i_operation),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_side         (i_side),
        .o_removed      (o_removed),
        .o_rejected     (o_rejected),
        .o_wall_present (o_wall_present)
    );

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_removed && o_rejected))
        else $error("offer result both removed and rejected");

    a_wall_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_removed || o_rejected)) |-> !o_wall_present)
        else $error("wall bit set on an offer result");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_in_ready)
        else $error("request accepted before the clearing pass");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request accepted while one is in work");

endmodule

`default_nettype wire
